/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the capture timer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/pcpd_pkg.sv */
// ----------------------------------------------------------------------------
// pcpd_pkg
// Types and fixed constants of the PWM period and duty capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcpd_pkg;

   localparam int PRESCALE_W  = 17;
   localparam int RELOAD_W    = 16;
   localparam int CLOCK_W     = 29;
   localparam int US_W        = 32;
   localparam int US_CONST_W  = 20;
   localparam int SCALE_W     = PRESCALE_W + US_CONST_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 29;

   localparam logic [US_CONST_W-1:0] US_PER_S = 20'd1000000;

   localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 17'd1;
   localparam logic [RELOAD_W-1:0]   RELOAD_RESET   = 16'hFFFF;
   localparam logic [CLOCK_W-1:0]    CLOCK_RESET    = 29'd64000000;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_PRESCALE = 2'd0;
   localparam csr_index_type CSR_RELOAD   = 2'd1;
   localparam csr_index_type CSR_CLOCK    = 2'd2;

   // one finished tick-to-microsecond conversion
   typedef struct packed {
      logic            sat;
      logic [US_W-1:0] us;
   } conv_result_type;

endpackage

`default_nettype wire

/* sv/pcpd_conv.sv */
// ----------------------------------------------------------------------------
// pcpd_conv
// Tick to microsecond converter: shift-add multiply by the scale, then a
// restoring divide by the clock rate, all on one shared add/subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pcpd_conv #(
   parameter int TICK_W = 17
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [TICK_W-1:0]                  ticks,
   input  wire logic [pcpd_pkg::SCALE_W-1:0]       scale,
   input  wire logic [pcpd_pkg::CLOCK_W-1:0]       divisor,
   output      logic                               done,
   output      pcpd_pkg::conv_result_type          result
);

   import pcpd_pkg::*;

   localparam int PROD_W    = TICK_W + SCALE_W;
   localparam int DVD_W     = 2 * US_W;
   localparam int ACC_W     = (PROD_W > DVD_W) ? PROD_W : DVD_W + 1;
   localparam int MAX_STEPS = (TICK_W > US_W) ? TICK_W : US_W;
   localparam int CNT_W     = $clog2(MAX_STEPS);

   typedef enum logic [2:0] {
      C_IDLE,
      C_MUL,
      C_CHECK,
      C_DIV,
      C_DONE
   } conv_state_type;

   conv_state_type          state_ff, state_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [ACC_W-1:0]        mcand_ff, mcand_in;
   logic [TICK_W-1:0]       mplier_ff, mplier_in;
   logic [CLOCK_W-1:0]      div_ff, div_in;
   logic [CNT_W-1:0]        step_ff, step_in;
   logic                    sat_ff, sat_in;

   // shared add/subtract unit
   logic [ACC_W-1:0]        op_a, op_b;
   logic                    sub;
   logic [ACC_W:0]          sum;
   logic                    no_borrow;
   logic [US_W-1:0]         rem_sh;
   logic [US_W-1:0]         new_rem;
   logic                    high_set;

   assign rem_sh    = {acc_ff[DVD_W-2:US_W], acc_ff[US_W-1]};
   assign high_set  = |acc_ff[ACC_W-1:DVD_W];

   always_comb begin
      op_a = acc_ff;
      op_b = mplier_ff[0] ? mcand_ff : '0;
      sub  = 1'b0;
      case (state_ff)
         C_CHECK: begin
            op_a = ACC_W'(acc_ff[DVD_W-1:US_W]);
            op_b = ACC_W'(div_ff);
            sub  = 1'b1;
         end
         C_DIV: begin
            op_a = ACC_W'(rem_sh);
            op_b = ACC_W'(div_ff);
            sub  = 1'b1;
         end
         default: ;
      endcase
   end

   assign sum       = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + (ACC_W+1)'(sub);
   assign no_borrow = sum[ACC_W];
   assign new_rem   = no_borrow ? sum[US_W-1:0] : rem_sh;

   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      div_in    = div_ff;
      step_in   = step_ff;
      sat_in    = sat_ff;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               acc_in    = '0;
               mcand_in  = ACC_W'(scale);
               mplier_in = ticks;
               div_in    = divisor;
               step_in   = '0;
               sat_in    = 1'b0;
               state_in  = C_MUL;
            end
         end
         C_MUL: begin
            acc_in    = sum[ACC_W-1:0];
            mcand_in  = {mcand_ff[ACC_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[TICK_W-1:1]};
            step_in   = step_ff + 1'b1;
            if (step_ff == CNT_W'(TICK_W - 1)) begin
               state_in = C_CHECK;
            end
         end
         C_CHECK: begin
            // product beyond 64 bits, or quotient beyond 32 bits: clamp
            if (high_set || no_borrow) begin
               sat_in   = 1'b1;
               state_in = C_DONE;
            end else begin
               acc_in   = ACC_W'(acc_ff[DVD_W-1:0]);
               step_in  = '0;
               state_in = C_DIV;
            end
         end
         C_DIV: begin
            acc_in  = ACC_W'({new_rem, acc_ff[US_W-2:0], no_borrow});
            step_in = step_ff + 1'b1;
            if (step_ff == CNT_W'(US_W - 1)) begin
               state_in = C_DONE;
            end
         end
         C_DONE: begin
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      div_ff    <= div_in;
      step_ff   <= step_in;
      sat_ff    <= sat_in;
   end

   assign done       = (state_ff == C_DONE);
   assign result.sat = sat_ff;
   assign result.us  = sat_ff ? '1 : acc_ff[US_W-1:0];

   `ASSERT_IMPLIES(a_start_when_idle, clock, reset, start, state_ff == C_IDLE, "start while busy")
   `ASSERT_IMPLIES(a_done_path, clock, reset, done, $past(state_ff) == C_DIV || $past(state_ff) == C_CHECK, "done outside divide path")
   `ASSERT_IMPLIES(a_divisor_nonzero, clock, reset, state_ff == C_DIV, div_ff != '0, "divide by zero")

endmodule

`default_nettype wire

/* sv/pwm_capture_period_duty.sv */
// ----------------------------------------------------------------------------
// pwm_capture_period_duty: PWM period and duty from timer input captures.
// A capture word is taken only while idle, so the next word waits until the result word
// of the last is loaded, which waits while an earlier result word is not yet taken.
// A conversion that clamps at the check skips its divide steps.
// Each conversion: COUNTER_WIDTH+1 multiply steps, one check, 32 divide steps.
// Synchronous reset restores the register defaults and the capture state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pwm_capture_period_duty #(
   parameter int  COUNTER_WIDTH = 16,
   localparam int REQ_W = ((COUNTER_WIDTH + 7) / 8) * 8,
   localparam int RSP_RAW_W = 2 * COUNTER_WIDTH + 1 + 2 * pcpd_pkg::US_W + 2,
   localparam int RSP_W = ((RSP_RAW_W + 7) / 8) * 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output      logic                                  req_tready,
   // captured_count
   input  wire logic [REQ_W-1:0]                      req_tdata,
   output      logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // duty_ticks, period_ticks, duty_us, period_us, next_edge_falling, time_saturated
   output      logic [RSP_W-1:0]                      rsp_tdata,
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [pcpd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [pcpd_pkg::CSR_DATA_W-1:0]       csr_data
);

   import pcpd_pkg::*;

   localparam int CW     = COUNTER_WIDTH;
   localparam int TICK_W = COUNTER_WIDTH + 1;

   typedef enum logic [2:0] {
      T_IDLE,
      T_DUTY_GO,
      T_DUTY_WAIT,
      T_PER_GO,
      T_PER_WAIT,
      T_OUT
   } top_state_type;

   top_state_type          state_ff;
   logic [PRESCALE_W-1:0]  prescale_ff;
   logic [RELOAD_W-1:0]    reload_ff;
   logic [CLOCK_W-1:0]     clock_hz_ff;

   logic [CW-1:0]          prev_count_ff;
   logic                   prev_valid_ff;
   logic                   expect_falling_ff;
   logic [CW-1:0]          duty_ff;
   logic [TICK_W-1:0]      period_ff;

   logic [SCALE_W-1:0]     scale_ff;
   logic [CLOCK_W-1:0]     divisor_ff;
   logic [US_W-1:0]        duty_us_ff;
   logic                   sat_ff;
   logic                   rsp_valid_ff;
   logic [RSP_W-1:0]       rsp_data_ff;

   logic                   req_fire;
   logic [CW-1:0]          cnt;
   logic [RELOAD_W:0]      reload_p1;
   logic [CW-1:0]          tick;
   logic [TICK_W-1:0]      period_sum;
   logic                   conv_start;
   logic [TICK_W-1:0]      conv_ticks;
   logic                   conv_done;
   conv_result_type        conv_res;

   assign req_tready = (state_ff == T_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // distance from the previous capture, wrapped at auto_reload + 1
   assign cnt        = req_tdata[CW-1:0];
   assign reload_p1  = {1'b0, reload_ff} + 1'b1;
   assign tick       = cnt - prev_count_ff + ((cnt < prev_count_ff) ? CW'(reload_p1) : '0);
   assign period_sum = {1'b0, duty_ff} + {1'b0, tick};

   assign conv_start = (state_ff == T_DUTY_GO) || (state_ff == T_PER_GO);
   assign conv_ticks = (state_ff == T_DUTY_GO) ? TICK_W'(duty_ff) : period_ff;

   pcpd_conv #(
      .TICK_W (TICK_W)
   ) u_conv (
      .clock   (clock),
      .reset   (reset),
      .start   (conv_start),
      .ticks   (conv_ticks),
      .scale   (scale_ff),
      .divisor (divisor_ff),
      .done    (conv_done),
      .result  (conv_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= T_IDLE;
         prescale_ff       <= PRESCALE_RESET;
         reload_ff         <= RELOAD_RESET;
         clock_hz_ff       <= CLOCK_RESET;
         prev_count_ff     <= '0;
         prev_valid_ff     <= 1'b0;
         expect_falling_ff <= 1'b1;
         duty_ff           <= '0;
         period_ff         <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PRESCALE: prescale_ff <= csr_data[PRESCALE_W-1:0];
               CSR_RELOAD:   reload_ff   <= csr_data[RELOAD_W-1:0];
               CSR_CLOCK:    clock_hz_ff <= csr_data[CLOCK_W-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_tready && (state_ff != T_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            T_IDLE: begin
               if (req_fire) begin
                  if (prev_valid_ff) begin
                     if (expect_falling_ff) begin
                        duty_ff <= tick;
                     end else if (duty_ff != '0) begin
                        period_ff <= period_sum;
                     end
                  end
                  expect_falling_ff <= !expect_falling_ff;
                  prev_count_ff     <= cnt;
                  prev_valid_ff     <= 1'b1;
                  scale_ff          <= SCALE_W'(prescale_ff) * SCALE_W'(US_PER_S);
                  divisor_ff        <= (clock_hz_ff == '0) ? CLOCK_W'(1) : clock_hz_ff;
                  state_ff          <= T_DUTY_GO;
               end
            end
            T_DUTY_GO: begin
               state_ff <= T_DUTY_WAIT;
            end
            T_DUTY_WAIT: begin
               if (conv_done) begin
                  duty_us_ff <= conv_res.us;
                  sat_ff     <= conv_res.sat;
                  state_ff   <= T_PER_GO;
               end
            end
            T_PER_GO: begin
               state_ff <= T_PER_WAIT;
            end
            T_PER_WAIT: begin
               if (conv_done) begin
                  state_ff <= T_OUT;
               end
            end
            T_OUT: begin
               // hold until the output register is free; the converter keeps its result
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= RSP_W'({sat_ff | conv_res.sat, expect_falling_ff,
                                          conv_res.us, duty_us_ff, period_ff, duty_ff});
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= T_IDLE;
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_NEXT(a_polarity_flips, clock, reset, req_fire, expect_falling_ff != $past(expect_falling_ff), "polarity did not toggle")
   `ASSERT_IMPLIES(a_done_expected, clock, reset, conv_done, state_ff == T_DUTY_WAIT || state_ff == T_PER_WAIT, "unexpected conversion done")
   `ASSERT_IMPLIES(a_rsp_from_out, clock, reset, rsp_valid_ff && !$past(rsp_valid_ff), $past(state_ff) == T_OUT, "result word loaded outside output state")

endmodule

`default_nettype wire

/* bench/pcpd_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcpd_checker
// Watches the capture, result and register channels of the PWM capture block.
// It tracks the edge polarity, the high time and the period, converts both to
// microseconds, and compares every result word with the oldest prediction.
// ----------------------------------------------------------------------------

module pcpd_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   // captured_count
   input  wire logic [15:0]                      req_tdata,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // duty_ticks, period_ticks, duty_us, period_us, next_edge_falling, time_saturated
   input  wire logic [103:0]                     rsp_tdata,
   input  wire logic                             csr_valid,
   input  wire logic                             csr_ready,
   input  wire logic [pcpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pcpd_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                                    fail_count,
   output int                                    outstanding
);
   import pcpd_pkg::*;

   localparam int PRINT_LIMIT = 20;

   // first member sits in the top bits, so the order is the reverse of the word
   typedef struct packed {
      logic            time_saturated;
      logic            next_edge_falling;
      logic [US_W-1:0] period_us;
      logic [US_W-1:0] duty_us;
      logic [16:0]     period_ticks;
      logic [15:0]     duty_ticks;
   } capture_result_type;

   logic [PRESCALE_W-1:0] prescale;
   logic [RELOAD_W-1:0]   reload;
   logic [CLOCK_W-1:0]    timer_hz;

   logic [15:0] last_count;
   bit          last_valid;
   bit          want_falling;
   logic [15:0] high_ticks;
   logic [16:0] period_ticks;

   capture_result_type pending_results[$];

   task automatic note_mismatch(input string what, input longint unsigned want,
                                input longint unsigned seen);
      if (fail_count < PRINT_LIMIT) begin
         $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, seen);
      end
      fail_count++;
   endtask

   function automatic conv_result_type to_micros(input logic [16:0] ticks);
      longint unsigned scaled;
      longint unsigned divisor;
      longint unsigned quotient;
      conv_result_type r;
      // a zero clock divides as one; products stay far below 64 bits
      divisor  = (timer_hz == '0) ? 64'd1 : 64'(timer_hz);
      scaled   = 64'(ticks) * 64'(US_PER_S) * 64'(prescale);
      quotient = scaled / divisor;
      r.sat    = (quotient > 64'hFFFF_FFFF);
      r.us     = r.sat ? '1 : quotient[US_W-1:0];
      return r;
   endfunction

   task automatic predict_capture(input logic [15:0] count);
      logic [17:0]        span;
      conv_result_type    duty_conv;
      conv_result_type    period_conv;
      capture_result_type r;
      if (last_valid) begin
         // a count below the previous one has wrapped past the reload value
         if (count >= last_count) begin
            span = 18'(count) - 18'(last_count);
         end else begin
            span = 18'(count) + 18'(reload) + 18'd1 - 18'(last_count);
         end
         if (want_falling) begin
            high_ticks = span[15:0];
         end else if (high_ticks != '0) begin
            period_ticks = 17'(high_ticks) + 17'(span[15:0]);
         end
      end
      want_falling = !want_falling;
      last_count   = count;
      last_valid   = 1'b1;

      duty_conv   = to_micros(17'(high_ticks));
      period_conv = to_micros(period_ticks);
      r.duty_ticks        = high_ticks;
      r.period_ticks      = period_ticks;
      r.duty_us           = duty_conv.us;
      r.period_us         = period_conv.us;
      r.next_edge_falling = want_falling;
      r.time_saturated    = duty_conv.sat | period_conv.sat;
      pending_results.push_back(r);
   endtask

   always @(posedge clock) begin : monitor
      capture_result_type want;
      capture_result_type seen;
      if (reset) begin
         prescale     = PRESCALE_RESET;
         reload       = RELOAD_RESET;
         timer_hz     = CLOCK_RESET;
         last_count   = '0;
         last_valid   = 1'b0;
         want_falling = 1'b1;
         high_ticks   = '0;
         period_ticks = '0;
         pending_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PRESCALE: prescale = csr_data[PRESCALE_W-1:0];
               CSR_RELOAD:   reload   = csr_data[RELOAD_W-1:0];
               CSR_CLOCK:    timer_hz = csr_data[CLOCK_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_capture(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[$bits(capture_result_type)-1:0];
            if (pending_results.size() == 0) begin
               note_mismatch("result word with nothing pending", 0, seen.duty_ticks);
            end else begin
               want = pending_results.pop_front();
               if (seen.duty_ticks !== want.duty_ticks)
                  note_mismatch("duty_ticks", want.duty_ticks, seen.duty_ticks);
               if (seen.period_ticks !== want.period_ticks)
                  note_mismatch("period_ticks", want.period_ticks, seen.period_ticks);
               if (seen.duty_us !== want.duty_us)
                  note_mismatch("duty_us", want.duty_us, seen.duty_us);
               if (seen.period_us !== want.period_us)
                  note_mismatch("period_us", want.period_us, seen.period_us);
               if (seen.next_edge_falling !== want.next_edge_falling)
                  note_mismatch("next_edge_falling", want.next_edge_falling,
                                seen.next_edge_falling);
               if (seen.time_saturated !== want.time_saturated)
                  note_mismatch("time_saturated", want.time_saturated, seen.time_saturated);
            end
         end
      end
      outstanding = pending_results.size();
   end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the PWM period and duty capture block: directed captures over
// the wrap, polarity and conversion corner cases, then PWM-like capture trains
// with random high and low times under changing register settings and
// back-pressure. A checker module beside the block predicts and compares.
// ----------------------------------------------------------------------------

module tb;
   import pcpd_pkg::*;

   localparam int COUNT_W       = 16;
   localparam int REQ_W         = 16;
   localparam int RSP_W         = 104;
   localparam int HOLD_CYCLES   = 600;
   localparam int DRAIN_CYCLES  = 120;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_ITEMS   = 190;

   // index with no register behind it
   localparam csr_index_type CSR_SPARE = 2'd3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index  = CSR_PRESCALE;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   int fail_count;
   int outstanding;

   int send_idle_pct = 31;
   int recv_idle_pct = 56;
   bit hold_request  = 1'b0;
   bit hold_served   = 1'b0;

   // polarity and counter position as seen from the stimulus side
   logic [RELOAD_W-1:0] wrap_value   = RELOAD_RESET;
   bit                  edge_falling = 1'b1;
   int unsigned         counter_pos  = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   pwm_capture_period_duty u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   pcpd_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   task automatic send_capture(input logic [COUNT_W-1:0] count);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= count;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      edge_falling = !edge_falling;
      counter_pos  = count;
   endtask

   // leaves csr_valid high so back-to-back writes need no gap
   task automatic write_reg(input csr_index_type index, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic configure(input logic [PRESCALE_W-1:0] prescale,
                            input logic [RELOAD_W-1:0] reload,
                            input logic [CLOCK_W-1:0] timer_hz,
                            input bit touch_spare);
      drain();
      // fill the bits above the prescaler and reload values with junk; they must be dropped
      write_reg(CSR_PRESCALE, {12'($urandom), prescale});
      write_reg(CSR_RELOAD, {13'($urandom), reload});
      write_reg(CSR_CLOCK, timer_hz);
      if (touch_spare) begin
         write_reg(CSR_SPARE, '1);
      end
      csr_valid  <= 1'b0;
      wrap_value = reload;
   endtask

   // receiver: random stalls, plus one long hold-off once requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      int                    sent;
      int unsigned           modulus;
      int unsigned           high_t;
      int unsigned           low_t;
      int unsigned           burst;
      int unsigned           step;
      logic [PRESCALE_W-1:0] pick_prescale;
      logic [RELOAD_W-1:0]   pick_reload;
      logic [CLOCK_W-1:0]    pick_hz;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: first capture, zero duty, wrap and the widest period
      send_capture(16'd0);
      send_capture(16'd0);
      send_capture(16'd100);
      send_capture(16'hFFFF);
      send_capture(16'd0);
      send_capture(16'hFFFF);
      send_capture(16'hFFFE);
      send_capture(16'd1000);
      send_capture(16'd3000);

      // zero prescaler, zero clock, counts above a small reload value
      configure('0, 16'd99, '0, 1'b1);
      send_capture(16'd50);
      send_capture(16'd150);
      send_capture(16'hFFFF);
      send_capture(16'd10);
      send_capture(16'd99);
      send_capture(16'd0);

      // largest prescaler on a one hertz clock: every nonzero time saturates
      configure('1, 16'd1, 29'd1, 1'b0);
      send_capture(16'd0);
      send_capture(16'd1);
      send_capture(16'd0);
      send_capture(16'd1);
      send_capture(16'd1);
      send_capture(16'd0);

      // zero clock with a unit prescaler and short gaps
      configure(17'd1, 16'hFFFF, '0, 1'b0);
      send_capture(16'd10);
      send_capture(16'd13);
      send_capture(16'd20);
      send_capture(16'd5000);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(5))
            0: pick_prescale = 17'd1;
            1: pick_prescale = 17'd65536;
            2: pick_prescale = '1;
            3: pick_prescale = '0;
            default: pick_prescale = 17'($urandom_range(65536, 1));
         endcase
         case ($urandom_range(5))
            0: pick_reload = 16'd1;
            1: pick_reload = 16'hFFFF;
            2: pick_reload = '0;
            3: pick_reload = 16'($urandom_range(300, 2));
            default: pick_reload = 16'($urandom_range(65535, 1));
         endcase
         case ($urandom_range(6))
            0: pick_hz = 29'd1;
            1: pick_hz = 29'd400000000;
            2: pick_hz = '1;
            3: pick_hz = '0;
            4: pick_hz = CLOCK_RESET;
            default: pick_hz = 29'($urandom_range(400000000, 1));
         endcase
         configure(pick_prescale, pick_reload, pick_hz, 1'b0);

         if (phase == 3) begin
            send_idle_pct = 56;
            recv_idle_pct = 31;
         end
         if (phase == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_request  = 1'b1;
         end

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(99) < 15) begin
               // noise: any count, above the reload value too
               send_capture(16'($urandom_range(65535)));
               sent++;
            end else begin
               // a PWM train: fixed high and low time with a little jitter
               modulus = 32'(wrap_value) + 1;
               high_t  = $urandom_range(wrap_value);
               low_t   = $urandom_range(wrap_value);
               burst   = $urandom_range(20, 4);
               repeat (burst) begin
                  step = edge_falling ? high_t : low_t;
                  if ($urandom_range(9) == 0) begin
                     step += $urandom_range(3);
                  end
                  send_capture(16'((counter_pos + step) % modulus));
                  sent++;
               end
            end
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
